>>> rtl/core/echo_escape_decoder_top_macros.svh
// Assertion macros used by the checker of the escape decoder.
`ifndef ECHO_ESCAPE_DECODER_TOP_MACROS_SVH
`define ECHO_ESCAPE_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ECD_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ECD_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

>>> rtl/core/ecd_pkg.sv
`timescale 1ns / 1ps

package ecd_pkg;

  // One queue entry: the results that a single input beat causes.
  typedef struct packed {
    logic       two;    // two result beats: byte0 then byte1
    logic       has0;   // byte0 carries a byte (else status-only result)
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       stop;   // stop status for the final result of the entry
  } cmd_t;

  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

endpackage

>>> rtl/core/ecd_front.sv
`timescale 1ns / 1ps

module ecd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  input  logic [7:0]    s_axis_tdata_i,
  input  logic          s_axis_tlast_i,
  output logic          s_axis_tready_o,
  input  logic          q_full_i,
  output logic          q_push_o,
  output ecd_pkg::cmd_t q_data_o
);
  import ecd_pkg::*;

  typedef enum logic [2:0] {
    ModeNormal  = 3'd0,
    ModeEscape  = 3'd1,
    ModeOctal   = 3'd2,
    ModeHex     = 3'd3,
    ModeStopped = 3'd4
  } mode_e;

  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharEsc    = 8'h1B;

  mode_e      mode_q, mode_d;
  logic [8:0] acc_q, acc_d;
  logic [1:0] cnt_q, cnt_d;
  logic       emit;
  cmd_t       cmd;
  logic       accept;

  assign s_axis_tready_o = !q_full_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign q_push_o        = accept && emit;
  assign q_data_o        = cmd;

  always_comb begin
    logic [7:0] b;
    logic       last;
    logic [3:0] dval;
    logic       is_dig;
    logic       octal;
    logic [8:0] acc_n;
    logic [1:0] cnt_n;
    logic [1:0] maxd;

    b      = s_axis_tdata_i;
    last   = s_axis_tlast_i;
    octal  = (mode_q == ModeOctal);
    maxd   = octal ? 2'd3 : 2'd2;
    dval   = 4'd0;
    is_dig = 1'b0;
    if (b inside {[8'h30:8'h39]}) begin
      dval   = b[3:0];
      is_dig = 1'b1;
    end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      dval   = b[3:0] + 4'd9;
      is_dig = 1'b1;
    end
    if (octal && dval[3]) begin
      is_dig = 1'b0;
    end
    acc_n = (octal ? {acc_q[5:0], 3'b000} : {acc_q[4:0], 4'b0000}) + {5'd0, dval};
    cnt_n = cnt_q + 2'd1;

    emit      = 1'b0;
    cmd.two   = 1'b0;
    cmd.has0  = 1'b1;
    cmd.byte0 = 8'd0;
    cmd.byte1 = b;
    cmd.stop  = 1'b0;
    mode_d    = mode_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;

    case (mode_q)
      ModeStopped: begin
      end
      ModeEscape: begin
        mode_d = ModeNormal;
        emit   = 1'b1;
        case (b)
          8'h63: begin  // c: suppress the rest of the string
            mode_d = ModeStopped;
            emit   = 1'b0;
          end
          8'h30, 8'h78: begin
            mode_d = (b == 8'h30) ? ModeOctal : ModeHex;
            acc_d  = 9'd0;
            cnt_d  = 2'd0;
            emit   = last;
          end
          8'h6E:      cmd.byte0 = 8'h0A;
          8'h74:      cmd.byte0 = 8'h09;
          8'h61:      cmd.byte0 = 8'h07;
          8'h62:      cmd.byte0 = 8'h08;
          8'h66:      cmd.byte0 = 8'h0C;
          8'h72:      cmd.byte0 = 8'h0D;
          8'h76:      cmd.byte0 = 8'h0B;
          CharBslash: cmd.byte0 = CharBslash;
          8'h65:      cmd.byte0 = CharEsc;
          default: begin
            // Unknown escape: the backslash and the character both pass.
            cmd.two   = 1'b1;
            cmd.byte0 = CharBslash;
          end
        endcase
      end
      ModeOctal, ModeHex: begin
        if (!is_dig) begin
          // Digits end; the terminator is text or opens an escape.
          emit      = 1'b1;
          cmd.byte0 = acc_q[7:0];
          if (b == CharBslash && !last) begin
            mode_d = ModeEscape;
          end else begin
            cmd.two = 1'b1;
            mode_d  = ModeNormal;
          end
        end else begin
          acc_d = acc_n;
          cnt_d = cnt_n;
          if (cnt_n >= maxd || last) begin
            emit      = 1'b1;
            cmd.byte0 = acc_n[7:0];
            mode_d    = ModeNormal;
          end
        end
      end
      default: begin
        if (b == CharBslash && !last) begin
          mode_d = ModeEscape;
        end else begin
          emit      = 1'b1;
          cmd.byte0 = b;
          mode_d    = ModeNormal;
        end
      end
    endcase

    if (last) begin
      cmd.stop = (mode_d == ModeStopped);
      if (!emit) begin
        emit      = 1'b1;
        cmd.has0  = 1'b0;
        cmd.byte0 = 8'd0;
      end
      mode_d = ModeNormal;
      acc_d  = 9'd0;
      cnt_d  = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeNormal;
      acc_q  <= 9'd0;
      cnt_q  <= 2'd0;
    end else if (accept) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

>>> rtl/core/ecd_queue.sv
`timescale 1ns / 1ps

module ecd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ecd_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ecd_pkg::cmd_t pop_data_o
);
  import ecd_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == QCntW'(QDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + QCntW'(do_push) - QCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/core/ecd_back.sv
`timescale 1ns / 1ps

module ecd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  ecd_pkg::cmd_t q_data_i,
  output logic          q_pop_o,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [7:0]    m_axis_tdata_o,
  output logic [1:0]    m_axis_tuser_o,
  output logic          m_axis_tlast_o
);
  import ecd_pkg::*;

  logic       valid_q, valid_d;
  logic       phase_q, phase_d;
  logic [7:0] byte_q, byte_d;
  logic       has_q, has_d;
  logic       last_q, last_d;
  logic       stop_q, stop_d;
  logic       out_free, load;

  assign out_free = !valid_q || m_axis_tready_i;
  assign load     = out_free && q_valid_i;
  // A two-result entry stays at the head until its second beat is loaded.
  assign q_pop_o  = load && (!q_data_i.two || phase_q);

  always_comb begin
    valid_d = load ? 1'b1 : (valid_q && !m_axis_tready_i);
    phase_d = load ? (q_data_i.two && !phase_q) : phase_q;
    if (q_data_i.two && !phase_q) begin
      byte_d = q_data_i.byte0;
      has_d  = 1'b1;
      last_d = 1'b0;
      stop_d = 1'b0;
    end else if (q_data_i.two) begin
      byte_d = q_data_i.byte1;
      has_d  = 1'b1;
      last_d = 1'b1;
      stop_d = q_data_i.stop;
    end else begin
      byte_d = q_data_i.byte0;
      has_d  = q_data_i.has0;
      last_d = 1'b1;
      stop_d = q_data_i.stop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      has_q  <= has_d;
      last_q <= last_d;
      stop_q <= stop_d;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = byte_q;
  assign m_axis_tuser_o  = {stop_q, has_q};
  assign m_axis_tlast_o  = last_q;

endmodule

>>> rtl/core/echo_escape_decoder_top.sv
`timescale 1ns / 1ps

// Escape decoder in the style of echo -e: one string character is taken per beat on the
// slave side (tlast marks the last character of a string) and decoded bytes leave on the
// master side, with tlast on the final result of each input beat. The block takes one
// character per clock while the queue is not full; most characters yield one result, some
// none, and an unknown escape or a digit run ended by a plain character yields two, which
// occupies the output register for both beats and, once the two-entry queue between the
// classifier and the output stage is full, holds off the input. A result passes through
// the queue and then the output register. The last character of a string always gives at
// least one result; if it gives no byte, tuser[0] is low and the beat only carries the stop
// status in tuser[1], which is high when a backslash-c suppressed the rest of the string.
module echo_escape_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser_o,   // [0] has_byte, [1] stopped
  output logic       m_axis_tlast_o
);
  import ecd_pkg::*;

  logic q_push, q_full, q_pop, q_valid;
  cmd_t push_data, pop_data;

  ecd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tready_o (s_axis_tready_o),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_data_o        (push_data)
  );

  ecd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  ecd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_data_i        (pop_data),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

>>> rtl/core/ecd_checker.sv
`timescale 1ns / 1ps
`include "echo_escape_decoder_top_macros.svh"

module ecd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_i,
  input logic [7:0] s_axis_tdata_i,
  input logic       s_axis_tlast_i,
  input logic       m_axis_tvalid_i,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_i,
  input logic [1:0] m_axis_tuser_i,
  input logic       m_axis_tlast_i
);

  logic        out_stall;
  logic [11:0] out_beat;
  logic        status_only;
  logic        status_ok;
  logic        stop_seen;
  logic        stop_ok;
  logic        ctl_known;
  logic        in_beat;
  logic        in_known;

  assign out_stall   = m_axis_tvalid_i && !m_axis_tready_i;
  assign out_beat    = {m_axis_tvalid_i, m_axis_tdata_i, m_axis_tuser_i, m_axis_tlast_i};
  assign status_only = m_axis_tvalid_i && !m_axis_tuser_i[0];
  assign status_ok   = m_axis_tlast_i && (m_axis_tdata_i == 8'd0);
  assign stop_seen   = m_axis_tvalid_i && m_axis_tuser_i[1];
  assign stop_ok     = m_axis_tlast_i && !m_axis_tuser_i[0];
  assign ctl_known   = !$isunknown({m_axis_tvalid_i, s_axis_tready_i});
  assign in_beat     = s_axis_tvalid_i && s_axis_tready_i;
  assign in_known    = !$isunknown({s_axis_tdata_i, s_axis_tlast_i});

  `ECD_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_stall, $stable(out_beat), "stalled beat moved")
  `ECD_ASSERT_IMPLY(a_status_last, clk_i, rst_ni, status_only, status_ok, "bad status beat")
  `ECD_ASSERT_IMPLY(a_stop_status, clk_i, rst_ni, stop_seen, stop_ok, "stop on a byte beat")
  `ECD_ASSERT_IMPLY(a_ctl_known, clk_i, rst_ni, 1'b1, ctl_known, "unknown handshake")
  `ECD_ASSERT_IMPLY(a_in_known, clk_i, rst_ni, in_beat, in_known, "unknown input beat")

endmodule

bind echo_escape_decoder_top ecd_checker u_ecd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o),
  .m_axis_tlast_i  (m_axis_tlast_o)
);
